// ===== hdl/euler_quaternion_vector_rotate_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euler quaternion vector rotate unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EULER_QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define EULER_QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

// same-cycle implication
`define EQVR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EQVR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/eqvr_pkg.sv =====
// ----------------------------------------------------------------------------
// eqvr_pkg
// Shared types, constants and rounding helpers of the quaternion rotate unit.
// ----------------------------------------------------------------------------
package eqvr_pkg;

	localparam int QUAT_BITS = 16;
	localparam int TRIG_BITS = 32;
	localparam int CORD_W    = 34;
	localparam int TABLE_LEN = 24;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	typedef logic signed [QUAT_BITS-1:0] quat_t;
	typedef logic signed [TRIG_BITS-1:0] trig_t;

	localparam logic [31:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// round half up from Q.60 to Q.30
	function automatic trig_t rnd30(input logic signed [2*TRIG_BITS:0] v);
		logic signed [2*TRIG_BITS:0] t;
		t = v + (65'sd1 <<< 29);
		return TRIG_BITS'(t >>> 30);
	endfunction

	// Q2.30 to Q1.14, half up, clamped to +-1.0
	function automatic quat_t to_q14(input trig_t v);
		logic signed [TRIG_BITS:0] t;
		logic signed [16:0]        r;
		t = TRIG_BITS'(v) + 33'sd32768;
		r = 17'(t >>> 16);
		if (r > 17'sd16384) begin
			r = 17'sd16384;
		end else if (r < -17'sd16384) begin
			r = -17'sd16384;
		end
		return QUAT_BITS'(r);
	endfunction

endpackage

// ===== hdl/euler_quaternion_vector_rotate_unit.sv =====
// done comes from the end of the valid chain (cord_v_s, then val_s1 to val_s10) and is
// registered together with the quat and rot outputs.
// Throughput: one request per cycle; busy stays low, there is no stall path.
// Timing is set by the input register, the CORDIC_STEPS unrolled CORDIC stages and
// ten multiply and round stages. arst_n clears the valid chain only; data regs are
// not reset.
// ----------------------------------------------------------------------------
// euler_quaternion_vector_rotate_unit
// YXZ Euler angles to quaternion via CORDIC, then rotation of a Q16.16 vector.
// ----------------------------------------------------------------------------
module euler_quaternion_vector_rotate_unit #(
	parameter int ANGLE_BITS   = 16,
	parameter int VECTOR_BITS  = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [ANGLE_BITS-1:0]  yaw_angle,
	input  logic signed [ANGLE_BITS-1:0]  pitch_angle,
	input  logic signed [ANGLE_BITS-1:0]  roll_angle,
	input  logic signed [VECTOR_BITS-1:0] vec_x,
	input  logic signed [VECTOR_BITS-1:0] vec_y,
	input  logic signed [VECTOR_BITS-1:0] vec_z,
	output logic                          done,
	output eqvr_pkg::quat_t               quat_x,
	output eqvr_pkg::quat_t               quat_y,
	output eqvr_pkg::quat_t               quat_z,
	output eqvr_pkg::quat_t               quat_w,
	output logic signed [VECTOR_BITS-1:0] rot_x,
	output logic signed [VECTOR_BITS-1:0] rot_y,
	output logic signed [VECTOR_BITS-1:0] rot_z
);
	import eqvr_pkg::*;

	localparam int VB = VECTOR_BITS;
	localparam int CS = CORDIC_STEPS;
	localparam int PW = 2 * TRIG_BITS + 1;
	localparam int FW = VB + QUAT_BITS;
	localparam int GW = VB + QUAT_BITS + 2;
	localparam int IW = VB + 4;
	localparam int HW = IW + QUAT_BITS;
	localparam int OW = HW + 1;
	localparam int TW = VB + 9;
	localparam int RW = VB + 10;
	localparam logic signed [RW-1:0] RMAX = {{(RW-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [RW-1:0] RMIN = ~RMAX;

	logic accept;
	logic signed [CORD_W-1:0] z_yaw, z_pitch, z_roll;

	// CORDIC stages: index k holds the state after k steps
	logic                     cord_v_s [0:CS];
	logic signed [CORD_W-1:0] cord_x_s [0:CS][0:2];
	logic signed [CORD_W-1:0] cord_y_s [0:CS][0:2];
	logic signed [CORD_W-1:0] cord_z_s [0:CS][0:2];
	logic signed [VB-1:0]     cord_vec_s [0:CS][0:2];

	logic              val_s1, val_s2, val_s3, val_s4, val_s5;
	logic              val_s6, val_s7, val_s8, val_s9, val_s10;
	logic signed [PW-1:0] pm_s1 [0:3];
	trig_t             cyaw_s1, syaw_s1, cyaw_s2, syaw_s2;
	trig_t             m_s2 [0:3];
	logic signed [PW-1:0] pa_s3 [0:3];
	logic signed [PW-1:0] pb_s3 [0:3];
	trig_t             qq_s4 [0:3];
	quat_t             q_s5 [0:3];
	quat_t             q_s6 [0:3];
	quat_t             q_s7 [0:3];
	logic signed [FW-1:0] pf_s6 [0:2][0:2];
	logic signed [IW-1:0] inr_s7 [0:2];
	logic signed [HW-1:0] ph_s8 [0:2][0:1];
	logic signed [TW-1:0] t_s9 [0:2];
	quat_t             q_s8 [0:3];
	quat_t             q_s9 [0:3];
	quat_t             q_s10 [0:3];
	logic signed [VB-1:0] rot_s10 [0:2];
	logic signed [VB-1:0] vec_s1 [0:2];
	logic signed [VB-1:0] vec_s2 [0:2];
	logic signed [VB-1:0] vec_s3 [0:2];
	logic signed [VB-1:0] vec_s4 [0:2];
	logic signed [VB-1:0] vec_s5 [0:2];
	logic signed [VB-1:0] vec_s6 [0:2];
	logic signed [VB-1:0] vec_s7 [0:2];
	logic signed [VB-1:0] vec_s8 [0:2];
	logic signed [VB-1:0] vec_s9 [0:2];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// half angle in turn units, 2^32 per turn
	assign z_yaw   = CORD_W'(yaw_angle) <<< (31 - ANGLE_BITS);
	assign z_roll  = CORD_W'(roll_angle) <<< (31 - ANGLE_BITS);
	assign z_pitch = -(CORD_W'(pitch_angle) <<< (31 - ANGLE_BITS));

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CS; k++) begin
				cord_v_s[k] <= 1'b0;
			end
			val_s1  <= 1'b0;
			val_s2  <= 1'b0;
			val_s3  <= 1'b0;
			val_s4  <= 1'b0;
			val_s5  <= 1'b0;
			val_s6  <= 1'b0;
			val_s7  <= 1'b0;
			val_s8  <= 1'b0;
			val_s9  <= 1'b0;
			val_s10 <= 1'b0;
		end else begin
			cord_v_s[0] <= accept;
			for (int k = 0; k < CS; k++) begin
				cord_v_s[k+1] <= cord_v_s[k];
			end
			val_s1  <= cord_v_s[CS];
			val_s2  <= val_s1;
			val_s3  <= val_s2;
			val_s4  <= val_s3;
			val_s5  <= val_s4;
			val_s6  <= val_s5;
			val_s7  <= val_s6;
			val_s8  <= val_s7;
			val_s9  <= val_s8;
			val_s10 <= val_s9;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			cord_x_s[0][a] <= CORD_W'(CORDIC_GAIN_Q30);
			cord_y_s[0][a] <= '0;
		end
		cord_z_s[0][0]   <= z_yaw;
		cord_z_s[0][1]   <= z_pitch;
		cord_z_s[0][2]   <= z_roll;
		cord_vec_s[0][0] <= vec_x;
		cord_vec_s[0][1] <= vec_y;
		cord_vec_s[0][2] <= vec_z;
	end

	for (genvar k = 0; k < CS; k++) begin : g_cord
		always_ff @(posedge clk) begin
			for (int a = 0; a < 3; a++) begin
				if (!cord_z_s[k][a][CORD_W-1]) begin
					cord_x_s[k+1][a] <= cord_x_s[k][a] - (cord_y_s[k][a] >>> k);
					cord_y_s[k+1][a] <= cord_y_s[k][a] + (cord_x_s[k][a] >>> k);
					cord_z_s[k+1][a] <= cord_z_s[k][a] - CORD_W'(ATAN_TURNS[k]);
				end else begin
					cord_x_s[k+1][a] <= cord_x_s[k][a] + (cord_y_s[k][a] >>> k);
					cord_y_s[k+1][a] <= cord_y_s[k][a] - (cord_x_s[k][a] >>> k);
					cord_z_s[k+1][a] <= cord_z_s[k][a] + CORD_W'(ATAN_TURNS[k]);
				end
				cord_vec_s[k+1][a] <= cord_vec_s[k][a];
			end
		end
	end

	trig_t c_yaw, s_yaw, c_pit, s_pit, c_rol, s_rol;
	assign c_yaw = TRIG_BITS'(cord_x_s[CS][0]);
	assign s_yaw = TRIG_BITS'(cord_y_s[CS][0]);
	assign c_pit = TRIG_BITS'(cord_x_s[CS][1]);
	assign s_pit = TRIG_BITS'(cord_y_s[CS][1]);
	assign c_rol = TRIG_BITS'(cord_x_s[CS][2]);
	assign s_rol = TRIG_BITS'(cord_y_s[CS][2]);

	always_ff @(posedge clk) begin
		// s1: pitch * roll products
		pm_s1[0] <= s_pit * c_rol;
		pm_s1[1] <= s_pit * s_rol;
		pm_s1[2] <= c_pit * s_rol;
		pm_s1[3] <= c_pit * c_rol;
		cyaw_s1  <= c_yaw;
		syaw_s1  <= s_yaw;
		vec_s1   <= cord_vec_s[CS];

		// s2: round partial quaternion
		m_s2[0] <= rnd30(pm_s1[0]);
		m_s2[1] <= rnd30(-pm_s1[1]);
		m_s2[2] <= rnd30(pm_s1[2]);
		m_s2[3] <= rnd30(pm_s1[3]);
		cyaw_s2 <= cyaw_s1;
		syaw_s2 <= syaw_s1;
		vec_s2  <= vec_s1;

		// s3: yaw * m products
		pa_s3[0] <= cyaw_s2 * m_s2[0];
		pb_s3[0] <= syaw_s2 * m_s2[2];
		pa_s3[1] <= cyaw_s2 * m_s2[1];
		pb_s3[1] <= syaw_s2 * m_s2[3];
		pa_s3[2] <= cyaw_s2 * m_s2[2];
		pb_s3[2] <= syaw_s2 * m_s2[0];
		pa_s3[3] <= cyaw_s2 * m_s2[3];
		pb_s3[3] <= syaw_s2 * m_s2[1];
		vec_s3   <= vec_s2;

		// s4: sum and round
		qq_s4[0] <= rnd30(pa_s3[0] + pb_s3[0]);
		qq_s4[1] <= rnd30(pa_s3[1] + pb_s3[1]);
		qq_s4[2] <= rnd30(pa_s3[2] - pb_s3[2]);
		qq_s4[3] <= rnd30(pa_s3[3] - pb_s3[3]);
		vec_s4   <= vec_s3;

		// s5: Q1.14
		for (int i = 0; i < 4; i++) begin
			q_s5[i] <= to_q14(qq_s4[i]);
		end
		vec_s5 <= vec_s4;

		// s6: inner products
		pf_s6[0][0] <= q_s5[1] * vec_s5[2];
		pf_s6[0][1] <= q_s5[2] * vec_s5[1];
		pf_s6[0][2] <= q_s5[3] * vec_s5[0];
		pf_s6[1][0] <= q_s5[2] * vec_s5[0];
		pf_s6[1][1] <= q_s5[0] * vec_s5[2];
		pf_s6[1][2] <= q_s5[3] * vec_s5[1];
		pf_s6[2][0] <= q_s5[0] * vec_s5[1];
		pf_s6[2][1] <= q_s5[1] * vec_s5[0];
		pf_s6[2][2] <= q_s5[3] * vec_s5[2];
		q_s6   <= q_s5;
		vec_s6 <= vec_s5;

		// s7: inner = cross(q, v) + w*v, rounded to Q.16
		for (int i = 0; i < 3; i++) begin
			inr_s7[i] <= IW'((GW'(pf_s6[i][0]) - GW'(pf_s6[i][1]) + GW'(pf_s6[i][2])
				+ GW'(8192)) >>> 14);
		end
		q_s7   <= q_s6;
		vec_s7 <= vec_s6;

		// s8: outer products
		ph_s8[0][0] <= q_s7[1] * inr_s7[2];
		ph_s8[0][1] <= q_s7[2] * inr_s7[1];
		ph_s8[1][0] <= q_s7[2] * inr_s7[0];
		ph_s8[1][1] <= q_s7[0] * inr_s7[2];
		ph_s8[2][0] <= q_s7[0] * inr_s7[1];
		ph_s8[2][1] <= q_s7[1] * inr_s7[0];
		q_s8   <= q_s7;
		vec_s8 <= vec_s7;

		// s9: 2*outer rounded to Q.16
		for (int i = 0; i < 3; i++) begin
			t_s9[i] <= TW'((OW'(ph_s8[i][0]) - OW'(ph_s8[i][1]) + OW'(4096)) >>> 13);
		end
		q_s9   <= q_s8;
		vec_s9 <= vec_s8;

		// s10: add and saturate
		for (int i = 0; i < 3; i++) begin
			logic signed [RW-1:0] r;
			r = RW'(vec_s9[i]) + RW'(t_s9[i]);
			if (r > RMAX) begin
				rot_s10[i] <= VB'(RMAX);
			end else if (r < RMIN) begin
				rot_s10[i] <= VB'(RMIN);
			end else begin
				rot_s10[i] <= VB'(r);
			end
		end
		q_s10 <= q_s9;
	end

	assign done   = val_s10;
	assign quat_x = q_s10[0];
	assign quat_y = q_s10[1];
	assign quat_z = q_s10[2];
	assign quat_w = q_s10[3];
	assign rot_x  = rot_s10[0];
	assign rot_y  = rot_s10[1];
	assign rot_z  = rot_s10[2];

endmodule

// ===== hdl/eqvr_checker.sv =====
// ----------------------------------------------------------------------------
// eqvr_checker
// Port-level checks of the quaternion rotate unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_quaternion_vector_rotate_unit_assert.svh"

module eqvr_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input eqvr_pkg::quat_t               quat_x,
	input eqvr_pkg::quat_t               quat_w
);
	import eqvr_pkg::*;

	localparam int LAT = CORDIC_STEPS + 11;

	`EQVR_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")
	`EQVR_ASSERT_NOW(a_done_has_request, done, $past(start && !busy, LAT),
		"done without a request")
	`EQVR_ASSERT_NEXT(a_request_done, start && !busy, ##(LAT-1) done, "request lost")
	`EQVR_ASSERT_NOW(a_quat_range, done,
		quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
		quat_w <= 16'sd16384 && quat_w >= -16'sd16384, "quaternion out of range")

endmodule

bind euler_quaternion_vector_rotate_unit eqvr_checker #(
	.CORDIC_STEPS(CORDIC_STEPS)
) u_eqvr_checker (.*);

// ===== bench/euler_quaternion_vector_rotate_unit_tb.sv =====
// ----------------------------------------------------------------------------
// euler_quaternion_vector_rotate_unit_tb
// Drives Euler angle and vector requests into the rotate unit. Each accepted
// request is run through a local CORDIC and quaternion model, and each done
// strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module euler_quaternion_vector_rotate_unit_tb;
	import eqvr_pkg::*;

	localparam int AB = 16;
	localparam int VB = 32;
	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 11;

	typedef struct {
		quat_t qx, qy, qz, qw;
		logic signed [VB-1:0] rx, ry, rz;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [AB-1:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
	logic signed [VB-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	quat_t quat_x, quat_y, quat_z, quat_w;
	logic signed [VB-1:0] rot_x, rot_y, rot_z;

	pose_t pending_poses[$];
	int n_errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int idle_pct = 0;

	euler_quaternion_vector_rotate_unit #(
		.ANGLE_BITS(AB), .VECTOR_BITS(VB), .CORDIC_STEPS(STEPS)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .done(done),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(4 * 400000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void half_sincos(input longint half, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		z = half;
		for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint round_q30(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clamp_q14(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	function automatic longint sat_vec(input longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (VB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic pose_t predict_pose(input logic signed [AB-1:0] ya, pa, ra,
			input logic signed [VB-1:0] vx, vy, vz);
		pose_t p;
		longint sc, yc, ys, pc, ps, rc, rs;
		longint mx, my, mz, mw, q[4], v[3], inr[3], o;
		sc = 64'sd1 <<< (31 - AB);
		half_sincos(longint'(ya) * sc, yc, ys);
		half_sincos(-longint'(pa) * sc, pc, ps);
		half_sincos(longint'(ra) * sc, rc, rs);
		// pitch (about X) times roll (about Z)
		mx = round_q30(ps * rc);
		my = round_q30(-ps * rs);
		mz = round_q30(pc * rs);
		mw = round_q30(pc * rc);
		// yaw (about Y) times that
		q[0] = clamp_q14(round_q30(yc * mx + ys * mz));
		q[1] = clamp_q14(round_q30(yc * my + ys * mw));
		q[2] = clamp_q14(round_q30(yc * mz - ys * mx));
		q[3] = clamp_q14(round_q30(yc * mw - ys * my));
		v[0] = vx; v[1] = vy; v[2] = vz;
		inr[0] = (q[1] * v[2] - q[2] * v[1] + q[3] * v[0] + 8192) >>> 14;
		inr[1] = (q[2] * v[0] - q[0] * v[2] + q[3] * v[1] + 8192) >>> 14;
		inr[2] = (q[0] * v[1] - q[1] * v[0] + q[3] * v[2] + 8192) >>> 14;
		p.qx = quat_t'(q[0]); p.qy = quat_t'(q[1]);
		p.qz = quat_t'(q[2]); p.qw = quat_t'(q[3]);
		o = q[1] * inr[2] - q[2] * inr[1];
		p.rx = VB'(sat_vec(v[0] + ((o + 4096) >>> 13)));
		o = q[2] * inr[0] - q[0] * inr[2];
		p.ry = VB'(sat_vec(v[1] + ((o + 4096) >>> 13)));
		o = q[0] * inr[1] - q[1] * inr[0];
		p.rz = VB'(sat_vec(v[2] + ((o + 4096) >>> 13)));
		return p;
	endfunction

	task automatic send_request(input logic signed [AB-1:0] ya, pa, ra,
			input logic signed [VB-1:0] vx, vy, vz);
		bit accepted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		yaw_angle <= ya; pitch_angle <= pa; roll_angle <= ra;
		vec_x <= vx; vec_y <= vy; vec_z <= vz;
		accepted = 0;
		while (!accepted) begin
			@(negedge clk);
			accepted = !busy;
			@(posedge clk);
		end
		pending_poses.push_back(predict_pose(ya, pa, ra, vx, vy, vz));
		n_sent++;
	endtask

	task automatic drain_requests();
		start <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint exp_v, act_v);
		if (exp_v != act_v) begin
			n_errors++;
			if (n_errors <= 10)
				$display("mismatch %s: expected %0d got %0d (result %0d)",
					name, exp_v, act_v, n_checked);
		end
	endtask

	always @(posedge clk) begin
		pose_t e;
		if (arst_n && done) begin
			if (pending_poses.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("mismatch: done with no request pending");
			end else begin
				e = pending_poses.pop_front();
				check_field("quat_x", e.qx, quat_x);
				check_field("quat_y", e.qy, quat_y);
				check_field("quat_z", e.qz, quat_z);
				check_field("quat_w", e.qw, quat_w);
				check_field("rot_x", e.rx, rot_x);
				check_field("rot_y", e.ry, rot_y);
				check_field("rot_z", e.rz, rot_z);
			end
			n_checked++;
		end
	end

	task automatic test_directed();
		logic signed [AB-1:0] angs[5] = '{16'sh0000, 16'sh8000, 16'sh7fff,
			16'sh4000, 16'shc000};
		for (int i = 0; i < 5; i++)
			send_request(angs[i], angs[(i + 1) % 5], angs[(i + 3) % 5],
				32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
		send_request(0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
		send_request(16'sh4000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_request(0, 16'sh2000, 16'sh2000, 32'sh80000000, 32'sh80000000,
			32'sh80000000);
		send_request(16'sh2000, 16'sh2000, 16'sh2000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff);
		send_request(16'sh8000, 16'sh8000, 16'sh8000, -1, 1, 0);
		send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 0, 32'sh80000000);
		send_request(16'shffff, 16'sh0001, 16'shffff, 0, 0, 0);
	endtask

	task automatic test_random(input int count, input int pct);
		logic signed [VB-1:0] vx, vy, vz;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				vx = $urandom; vy = $urandom; vz = $urandom;
			end else begin
				vx = $signed($urandom) >>> $urandom_range(24, 4);
				vy = $signed($urandom) >>> $urandom_range(24, 4);
				vz = $signed($urandom) >>> $urandom_range(24, 4);
			end
			send_request(AB'($urandom), AB'($urandom), AB'($urandom), vx, vy, vz);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500, 21);
		drain_requests();
		test_random(500, 87);
		test_random(500, 0);
		drain_requests();
		$display("covered %0d requests (angle extremes, saturating vectors, random) %s",
			n_sent, "with sparse, dense and no sender gaps");
		$display("checked %0d results, %0d field errors", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/eqvr_pkg.sv
hdl/euler_quaternion_vector_rotate_unit.sv
hdl/eqvr_checker.sv
bench/euler_quaternion_vector_rotate_unit_tb.sv
